// ===== hw/rtl/gfba_pkg.sv =====
package gfba_pkg;

  // Default geometry of the free list
  localparam int unsigned GroupSizeDef = 16;
  localparam int unsigned NumBlocksDef = 4096;

  // Block id width and stream payload widths
  localparam int unsigned BlkW     = 12;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TdataW   = 16;

  // Request kinds (s_axis_tuser)
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Result status codes (m_axis_tuser)
  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StEmpty  = 2'd1;
  localparam logic [StatusW-1:0] StZeroBk = 2'd2;

  // Reciprocal used to reduce a block id modulo the block count
  localparam int unsigned ModShift = 24;
  localparam int unsigned RecipW   = ModShift + 1;

endpackage

// ===== hw/rtl/grouped_free_block_allocator.sv =====
// Grouped free-block allocator: a free list kept as a chain of groups.
// Slave stream: one transaction per request. s_axis_tuser carries the kind
// (allocate or free), s_axis_tdata the block id to free (ignored on allocate).
// Master stream: exactly one transaction per request, in request order.
// m_axis_tdata carries the granted block (0 on free or failure), m_axis_tuser
// the status (ok, no free block, free of block 0 rejected).
// Every result passes through the output register. A free pushed into the
// head group, a rejected free and a failed allocate finish on accept; an
// allocate from the head group adds one read of the head memory (StPop).
// A free into a full head (spill) or an allocate of the link (refill) first
// forms the store address in StMod1, StMod2 and StMod3, then moves one group
// entry per cycle between head memory and spill store.
// A new request is taken whenever the sequencer is idle, even while the last
// result still waits in the output register; a stalled receiver holds that
// result, and the next finished result waits in a holding register until the
// output register frees up, with s_axis_tready low meanwhile.
// Reset leaves an empty list: head count one, link zero. The spill store
// needs no clearing, since an entry is only read after a spill wrote it.
module grouped_free_block_allocator #(
  parameter int unsigned GROUP_SIZE = gfba_pkg::GroupSizeDef,
  parameter int unsigned NUM_BLOCKS = gfba_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] block_number, [15:12] zero
  input  logic [gfba_pkg::TdataW-1:0]   s_axis_tdata,
  // [0] opcode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [11:0] granted_block, [15:12] zero
  output logic [gfba_pkg::TdataW-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [gfba_pkg::StatusW-1:0]  m_axis_tuser
);

  localparam int unsigned BlkW  = gfba_pkg::BlkW;
  localparam int unsigned StW   = gfba_pkg::StatusW;
  localparam int unsigned GW    = $clog2(GROUP_SIZE);
  localparam int unsigned CW    = $clog2(GROUP_SIZE + 1);
  localparam int unsigned BW    = $clog2(NUM_BLOCKS);
  localparam int unsigned Depth = NUM_BLOCKS * GROUP_SIZE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = BlkW + gfba_pkg::RecipW;
  localparam int unsigned QnW   = BlkW + BW + 1;
  localparam int unsigned Recip = (1 << gfba_pkg::ModShift) / NUM_BLOCKS;

  // Sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPop  = 3'd1;
  localparam logic [2:0] StMod1 = 3'd2;
  localparam logic [2:0] StMod2 = 3'd3;
  localparam logic [2:0] StMod3 = 3'd4;
  localparam logic [2:0] StMove = 3'd5;
  localparam logic [2:0] StWait = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [BlkW-1:0] link_q, link_d;       // head slot 0: link to next group
  logic            refill_q, refill_d;   // group move direction
  logic [BlkW-1:0] opd_q, opd_d;         // block being spilled to or refilled from
  logic [BlkW-1:0] quo_q, quo_d;
  logic [BW-1:0]   rem_q, rem_d;
  logic [AW-1:0]   base_q, base_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [GW-1:0]   pidx_q, pidx_d;
  logic [BlkW-1:0] resg_q, resg_d;
  logic [StW-1:0]  ress_q, ress_d;
  logic            mval_q, mval_d;
  logic [BlkW-1:0] mgr_q, mgr_d;
  logic [StW-1:0]  mst_q, mst_d;

  // Head group memory (slot 0 lives in link_q)
  logic [BlkW-1:0] head_mem [GROUP_SIZE];
  logic            head_re, head_we;
  logic [GW-1:0]   head_raddr, head_waddr;
  logic [BlkW-1:0] head_wdata, head_rdata_q;

  // Spill store: one group per block
  logic [BlkW-1:0] spill_mem [Depth];
  logic            spill_re, spill_we;
  logic [AW-1:0]   spill_raddr, spill_waddr;
  logic [BlkW-1:0] spill_wdata, spill_rdata_q;

  logic            s_fire, out_free;
  logic            fin_valid;
  logic [BlkW-1:0] fin_granted;
  logic [StW-1:0]  fin_status;
  logic [BlkW-1:0] in_blk;
  logic [CW-1:0]   cnt_dec;
  logic [PW-1:0]   prod;
  logic [QnW-1:0]  qn, rem_raw, rem_cor;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_q <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (spill_we) begin
      spill_mem[spill_waddr] <= spill_wdata;
    end
    if (spill_re) begin
      spill_rdata_q <= spill_mem[spill_raddr];
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mval_q || m_axis_tready;
  assign in_blk        = s_axis_tdata[BlkW-1:0];
  assign cnt_dec       = count_q - CW'(1);

  // Block id modulo NUM_BLOCKS: reciprocal estimate, then one correction
  assign prod    = PW'(opd_q) * PW'(Recip);
  assign qn      = QnW'(quo_q) * QnW'(NUM_BLOCKS);
  assign rem_raw = QnW'(opd_q) - qn;
  assign rem_cor = (rem_raw >= QnW'(NUM_BLOCKS)) ? rem_raw - QnW'(NUM_BLOCKS) : rem_raw;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    link_d      = link_q;
    refill_d    = refill_q;
    opd_d       = opd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    base_d      = base_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    resg_d      = resg_q;
    ress_d      = ress_q;
    head_re     = 1'b0;
    head_we     = 1'b0;
    head_raddr  = '0;
    head_waddr  = '0;
    head_wdata  = '0;
    spill_re    = 1'b0;
    spill_we    = 1'b0;
    spill_raddr = '0;
    spill_waddr = '0;
    spill_wdata = '0;
    fin_valid   = 1'b0;
    fin_granted = '0;
    fin_status  = gfba_pkg::StOk;

    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser == gfba_pkg::OpAlloc) begin
            if (count_q > CW'(1)) begin
              // pop the top id
              head_re    = 1'b1;
              head_raddr = cnt_dec[GW-1:0];
              count_d    = cnt_dec;
              state_d    = StPop;
            end else if (link_q != '0) begin
              // only the link is left: refill from its group, grant it
              opd_d    = link_q;
              refill_d = 1'b1;
              state_d  = StMod1;
            end else begin
              fin_valid  = 1'b1;
              fin_status = gfba_pkg::StEmpty;
            end
          end else begin
            if (in_blk == '0) begin
              fin_valid  = 1'b1;
              fin_status = gfba_pkg::StZeroBk;
            end else if (count_q == CW'(GROUP_SIZE)) begin
              // head full: spill it into the freed block
              opd_d    = in_blk;
              refill_d = 1'b0;
              state_d  = StMod1;
            end else begin
              head_we    = 1'b1;
              head_waddr = count_q[GW-1:0];
              head_wdata = in_blk;
              count_d    = count_q + CW'(1);
              fin_valid  = 1'b1;
            end
          end
        end
      end
      StPop: begin
        fin_valid   = 1'b1;
        fin_granted = head_rdata_q;
      end
      StMod1: begin
        quo_d   = prod[gfba_pkg::ModShift +: BlkW];
        state_d = StMod2;
      end
      StMod2: begin
        rem_d   = rem_cor[BW-1:0];
        state_d = StMod3;
      end
      StMod3: begin
        base_d  = AW'(rem_q) * AW'(GROUP_SIZE);
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = StMove;
      end
      StMove: begin
        // issue one read per cycle, write the data back in the following cycle
        if (idx_q != CW'(GROUP_SIZE)) begin
          if (refill_q) begin
            spill_re    = 1'b1;
            spill_raddr = base_q + AW'(idx_q);
          end else begin
            head_re    = 1'b1;
            head_raddr = idx_q[GW-1:0];
          end
          idx_d  = idx_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = idx_q[GW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (refill_q) begin
            if (pidx_q == '0) begin
              link_d = spill_rdata_q;
            end else begin
              head_we    = 1'b1;
              head_waddr = pidx_q;
              head_wdata = spill_rdata_q;
            end
          end else begin
            spill_we    = 1'b1;
            spill_waddr = base_q + AW'(pidx_q);
            spill_wdata = (pidx_q == '0) ? link_q : head_rdata_q;
          end
        end
        if (pend_q && idx_q == CW'(GROUP_SIZE)) begin
          fin_valid = 1'b1;
          if (refill_q) begin
            count_d     = CW'(GROUP_SIZE);
            fin_granted = opd_q;
          end else begin
            count_d = CW'(1);
            link_d  = opd_q;
          end
        end
      end
      StWait: begin
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register and holding register for a result that finds it busy
  always_comb begin
    mval_d = mval_q && !m_axis_tready;
    mgr_d  = mgr_q;
    mst_d  = mst_q;
    if (state_q == StWait) begin
      if (out_free) begin
        mval_d  = 1'b1;
        mgr_d   = resg_q;
        mst_d   = ress_q;
      end
    end else if (fin_valid && out_free) begin
      mval_d = 1'b1;
      mgr_d  = fin_granted;
      mst_d  = fin_status;
    end
  end

  logic [2:0] state_n;
  logic [BlkW-1:0] resg_n;
  logic [StW-1:0]  ress_n;

  always_comb begin
    state_n = state_d;
    resg_n  = resg_d;
    ress_n  = ress_d;
    if (state_q == StWait) begin
      if (out_free) begin
        state_n = StIdle;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        state_n = StIdle;
      end else begin
        // hold the result until the output register drains
        resg_n  = fin_granted;
        ress_n  = fin_status;
        state_n = StWait;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= CW'(1);
      link_q  <= '0;
      pend_q  <= 1'b0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_n;
      count_q <= count_d;
      link_q  <= link_d;
      pend_q  <= pend_d;
      mval_q  <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    refill_q <= refill_d;
    opd_q    <= opd_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    base_q   <= base_d;
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    resg_q   <= resg_n;
    ress_q   <= ress_n;
    mgr_q    <= mgr_d;
    mst_q    <= mst_d;
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {(gfba_pkg::TdataW - BlkW)'(0), mgr_q};
  assign m_axis_tuser  = mst_q;

endmodule
